>>> sv/swrc_pkg.sv
package swrc_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEARCH_LO  = 3'd0,
        REG_SEARCH_HI  = 3'd1,
        REG_SEARCH_LEN = 3'd2,
        REG_REPLACE_LO = 3'd3,
        REG_REPLACE_HI = 3'd4,
        REG_REPLACE_LEN = 3'd5
    } cfg_reg_t;

    // Sentence punctuation and letter bounds.
    localparam logic [BYTE_W-1:0] CHAR_PERIOD   = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_QUESTION = 8'h3F;
    localparam logic [BYTE_W-1:0] CHAR_BANG     = 8'h21;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET   = 8'h20;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_REPLACE,
        SEQ_FLUSH
    } seq_state_t;

    // One result byte with its framing flags.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_last;
        logic              text_done;
    } out_item_t;

    // Control shared by every cell of the window chain.
    typedef struct packed {
        logic              load_en;
        logic              shift;
        logic [LEN_W-1:0]  load_idx;
        logic [BYTE_W-1:0] in_byte;
    } cell_ctl_t;

    // Byte idx of a 16-byte word held in two 64-bit registers; bytes past 15 read as zero.
    function automatic logic [BYTE_W-1:0] word_byte(input logic [WORD_W-1:0] lo,
                                                    input logic [WORD_W-1:0] hi,
                                                    input logic [LEN_W-1:0]  idx);
        logic [2*WORD_W-1:0] w;
        w = {hi, lo};
        if (idx[LEN_W-1]) begin
            return '0;
        end
        return w[{idx[LEN_W-2:0], 3'b000} +: BYTE_W];
    endfunction

endpackage

>>> sv/swrc_cell.sv
module swrc_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                         aclk,
    input  swrc_pkg::cell_ctl_t          ctl,
    input  logic                         active,
    input  logic [swrc_pkg::BYTE_W-1:0]  word_byte,
    input  logic [swrc_pkg::BYTE_W-1:0]  right_post,
    output logic [swrc_pkg::BYTE_W-1:0]  post,
    output logic                         eq
);

    logic [swrc_pkg::BYTE_W-1:0] byte_reg;
    logic [swrc_pkg::BYTE_W-1:0] byte_next;
    logic                        load_here;

    // The new byte lands in the cell whose place equals the fill count.
    assign load_here = ctl.load_en && (int'(ctl.load_idx) == CELL_IDX);
    assign post      = load_here ? ctl.in_byte : byte_reg;
    assign eq        = !active || (post == word_byte);
    assign byte_next = ctl.shift ? right_post : post;

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

endmodule

>>> sv/swrc_out_fifo.sv
module swrc_out_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  swrc_pkg::out_item_t    push_item,
    output logic                   full,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output swrc_pkg::out_item_t    pop_item
);

    swrc_pkg::out_item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign full      = (cnt_reg == 2'd2);
    assign pop_valid = (cnt_reg != 2'd0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> sv/stream_word_replace_capitalize_unit.sv
// Streaming find-and-replace with sentence capitalization. Text arrives one byte per
// transfer on the s_ side; s_tlast marks the final byte of a text and flushes any bytes
// still held for matching. Every leftmost, non-overlapping, case-exact occurrence of the
// search word is replaced by the replacement word (an empty replacement deletes it), and
// the first letter of a text or after '.', '?' or '!' is made upper case. Each m_ transfer
// carries one result byte; m_tlast marks the last byte caused by one input transfer and
// m_tuser the last byte of a whole text. An input byte that causes at most one result is
// taken every cycle while the output queue has room. Input is held off while a byte that
// completes a match sends its replacement and while a final byte flushes the held bytes,
// one byte per cycle as long as the two-entry output queue has room for it. The block
// is ready straight after reset and needs no clearing pass. Write configuration only
// while no text is in progress; writing the search length drops any held bytes.
module stream_word_replace_capitalize_unit #(
    parameter int SEARCH_MAX  = 16,
    parameter int REPLACE_MAX = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input text stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // in_byte
    input  logic                              s_tlast,   // text_last
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // out_byte
    output logic                              m_tlast,   // run_last
    output logic [0:0]                        m_tuser,   // text_done
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swrc_pkg::WORD_W-1:0]       cfg_data
);

    localparam int LW = swrc_pkg::LEN_W;
    localparam int BW = swrc_pkg::BYTE_W;

    // Configuration registers.
    logic [swrc_pkg::WORD_W-1:0] search_lo_reg, search_hi_reg;
    logic [swrc_pkg::WORD_W-1:0] replace_lo_reg, replace_hi_reg;
    logic [LW-1:0]               search_len_reg, replace_len_reg;
    logic                        cfg_we;
    logic                        search_len_we;

    // Effective lengths after the zero and maximum limits.
    logic [LW-1:0] sl_eff, rl_eff;

    // Sequencer state.
    swrc_pkg::seq_state_t state_reg, state_next;
    logic [LW-1:0] count_reg, count_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic          job_last_reg, job_last_next;
    logic          cap_reg, cap_next;

    // Sequencer decisions.
    logic          accept;
    logic          fifo_full;
    logic          full_window;
    logic          window_match;
    logic          push;
    logic          push_final;
    logic          cur_last;
    logic          text_end;
    logic          go_replace, go_flush, job_done;
    logic [BW-1:0] raw_byte;
    logic [BW-1:0] cap_byte;
    logic          is_lower, is_upper, is_punct;

    swrc_pkg::cell_ctl_t ctl;
    swrc_pkg::out_item_t push_item, pop_item;

    logic [BW-1:0]         post_bytes [SEARCH_MAX];
    logic [SEARCH_MAX-1:0] eq_bits;

    assign cfg_ready     = 1'b1;
    assign cfg_we        = cfg_valid && cfg_ready;
    assign search_len_we = cfg_we && (cfg_index == swrc_pkg::REG_SEARCH_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            search_lo_reg   <= '0;
            search_hi_reg   <= '0;
            search_len_reg  <= LW'(1);
            replace_lo_reg  <= '0;
            replace_hi_reg  <= '0;
            replace_len_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                swrc_pkg::REG_SEARCH_LO:   search_lo_reg   <= cfg_data;
                swrc_pkg::REG_SEARCH_HI:   search_hi_reg   <= cfg_data;
                swrc_pkg::REG_SEARCH_LEN:  search_len_reg  <= cfg_data[LW-1:0];
                swrc_pkg::REG_REPLACE_LO:  replace_lo_reg  <= cfg_data;
                swrc_pkg::REG_REPLACE_HI:  replace_hi_reg  <= cfg_data;
                swrc_pkg::REG_REPLACE_LEN: replace_len_reg <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (search_len_reg == '0) begin
            sl_eff = LW'(1);
        end else if (int'(search_len_reg) > SEARCH_MAX) begin
            sl_eff = LW'(SEARCH_MAX);
        end else begin
            sl_eff = search_len_reg;
        end
        if (int'(replace_len_reg) > REPLACE_MAX) begin
            rl_eff = LW'(REPLACE_MAX);
        end else begin
            rl_eff = replace_len_reg;
        end
    end

    // The pending window: a chain of cells, oldest byte in cell 0. On a shift every
    // cell takes its right neighbor's byte, including one that arrives this cycle; the last takes zero.
    for (genvar gi = 0; gi < SEARCH_MAX; gi++) begin : g_cell
        logic [BW-1:0] right_byte;
        if (gi == SEARCH_MAX - 1) begin : g_end
            assign right_byte = '0;
        end else begin : g_mid
            assign right_byte = post_bytes[gi + 1];
        end
        swrc_cell #(
            .CELL_IDX (gi)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .active     (gi < int'(sl_eff)),
            .word_byte  (swrc_pkg::word_byte(search_lo_reg, search_hi_reg, LW'(gi))),
            .right_post (right_byte),
            .post       (post_bytes[gi]),
            .eq         (eq_bits[gi])
        );
    end

    assign window_match = &eq_bits;
    assign s_tready     = (state_reg == swrc_pkg::SEQ_IDLE) && !fifo_full;
    assign accept       = s_tvalid && s_tready;
    assign full_window  = (LW'(count_reg + LW'(1)) == sl_eff);

    // Sequencer outputs and datapath control.
    always_comb begin
        ctl.load_en   = accept;
        ctl.shift     = 1'b0;
        ctl.load_idx  = count_reg;
        ctl.in_byte   = s_tdata;
        push          = 1'b0;
        push_final    = 1'b0;
        raw_byte      = post_bytes[0];
        count_next    = count_reg;
        idx_next      = idx_reg;
        job_last_next = job_last_reg;
        cur_last      = 1'b0;
        text_end      = 1'b0;
        go_replace    = 1'b0;
        go_flush      = 1'b0;
        job_done      = 1'b0;

        unique case (state_reg)
            swrc_pkg::SEQ_IDLE: begin
                cur_last = s_tlast;
                if (accept) begin
                    job_last_next = s_tlast;
                    if (full_window && window_match) begin
                        // Match: the window empties and the replacement goes out.
                        count_next = '0;
                        raw_byte   = swrc_pkg::word_byte(replace_lo_reg, replace_hi_reg, '0);
                        if (rl_eff != '0) begin
                            push       = 1'b1;
                            push_final = (rl_eff == LW'(1));
                            go_replace = !push_final;
                            idx_next   = LW'(1);
                        end else begin
                            text_end = s_tlast;
                        end
                    end else if (full_window || s_tlast) begin
                        // Oldest byte leaves unchanged; at the end of a text the rest follows.
                        push       = 1'b1;
                        ctl.shift  = 1'b1;
                        count_next = count_reg;
                        push_final = !(s_tlast && (count_reg != '0));
                        go_flush   = !push_final;
                    end else begin
                        count_next = LW'(count_reg + LW'(1));
                    end
                end
            end
            swrc_pkg::SEQ_REPLACE: begin
                cur_last = job_last_reg;
                raw_byte = swrc_pkg::word_byte(replace_lo_reg, replace_hi_reg, idx_reg);
                if (!fifo_full) begin
                    push       = 1'b1;
                    push_final = (LW'(idx_reg + LW'(1)) == rl_eff);
                    idx_next   = LW'(idx_reg + LW'(1));
                    job_done   = push_final;
                end
            end
            swrc_pkg::SEQ_FLUSH: begin
                cur_last = 1'b1;
                if (!fifo_full) begin
                    push       = 1'b1;
                    ctl.shift  = 1'b1;
                    count_next = LW'(count_reg - LW'(1));
                    push_final = (count_reg == LW'(1));
                    job_done   = push_final;
                end
            end
            default: ;
        endcase

        if (push && push_final && cur_last) begin
            text_end = 1'b1;
        end
        if (search_len_we) begin
            count_next = '0;
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            swrc_pkg::SEQ_IDLE: begin
                if (go_replace) begin
                    state_next = swrc_pkg::SEQ_REPLACE;
                end else if (go_flush) begin
                    state_next = swrc_pkg::SEQ_FLUSH;
                end
            end
            swrc_pkg::SEQ_REPLACE,
            swrc_pkg::SEQ_FLUSH: begin
                if (job_done) begin
                    state_next = swrc_pkg::SEQ_IDLE;
                end
            end
            default: state_next = swrc_pkg::SEQ_IDLE;
        endcase
    end

    // Capitalization is applied as each byte enters the output queue, in text order.
    assign is_lower = (raw_byte >= swrc_pkg::CHAR_LOWER_A) && (raw_byte <= swrc_pkg::CHAR_LOWER_Z);
    assign is_upper = (raw_byte >= swrc_pkg::CHAR_UPPER_A) && (raw_byte <= swrc_pkg::CHAR_UPPER_Z);
    assign is_punct = (raw_byte == swrc_pkg::CHAR_PERIOD) || (raw_byte == swrc_pkg::CHAR_QUESTION)
                   || (raw_byte == swrc_pkg::CHAR_BANG);
    assign cap_byte = (cap_reg && is_lower) ? BW'(raw_byte - swrc_pkg::CASE_OFFSET) : raw_byte;

    always_comb begin
        cap_next = cap_reg;
        if (push) begin
            if (cap_reg && (is_lower || is_upper)) begin
                cap_next = 1'b0;
            end else if (is_punct) begin
                cap_next = 1'b1;
            end
        end
        // A new text always starts with a capital.
        if (text_end) begin
            cap_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= swrc_pkg::SEQ_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            job_last_reg <= 1'b0;
            cap_reg      <= 1'b1;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            job_last_reg <= job_last_next;
            cap_reg      <= cap_next;
        end
    end

    assign push_item.data      = cap_byte;
    assign push_item.run_last  = push_final;
    assign push_item.text_done = push_final && cur_last;

    swrc_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop_valid (m_tvalid),
        .pop_ready (m_tready),
        .pop_item  (pop_item)
    );

    assign m_tdata = pop_item.data;
    assign m_tlast = pop_item.run_last;
    assign m_tuser = pop_item.text_done;

endmodule

>>> sv/swrc_checker.sv
module swrc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    // The end of a text is always also the end of the run that caused it.
    a_done_is_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("text end flagged on a byte that is not the last of its run");

    // Nothing is offered in the cycle after reset.
    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result holds its byte and flags.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind stream_word_replace_capitalize_unit swrc_checker u_swrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
